[hdl/hdve_pkg.sv]
// Package for the hybrid delta varint encoder.
// Holds widths, register indexes and shared types; no dependencies.
package hdve_pkg;

   localparam int VALUE_BITS     = 48;
   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_BITS      = 16;
   localparam int RES_BITS       = (VALUE_BITS + 2 > 56) ? 56 : VALUE_BITS + 2;
   localparam int ACC_BITS       = VALUE_BITS + COEF_BITS + 1;
   localparam int MAC_PRED_BITS  = ACC_BITS - COEF_FRAC_BITS;
   localparam int PRED_BITS      = (MAC_PRED_BITS > VALUE_BITS) ? MAC_PRED_BITS : VALUE_BITS;
   localparam int DIFF_BITS      = (PRED_BITS + 1 > RES_BITS) ? PRED_BITS + 1 : RES_BITS;
   localparam int SUM_BITS       = ((PRED_BITS > RES_BITS) ? PRED_BITS : RES_BITS) + 1;
   localparam int SHIFT_BITS     = 64;
   localparam int RAW_BYTES      = SHIFT_BITS / 8;
   localparam int ADDR_BITS      = 4;
   localparam int DATA_BITS      = 32;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_ALPHA = 2'd1;
   localparam logic [1:0] REG_BETA  = 2'd2;

   localparam logic [COEF_BITS-1:0] ALPHA_RESET = COEF_BITS'(16384);
   localparam logic [COEF_BITS-1:0] BETA_RESET  = '0;

   localparam logic [7:0] GROUP_MASK = 8'h7F;
   localparam logic [7:0] CONT_BIT   = 8'h80;

   typedef logic signed [VALUE_BITS-1:0]    value_type;
   typedef logic signed [COEF_BITS-1:0]     coef_type;
   typedef logic signed [MAC_PRED_BITS-1:0] mac_pred_type;

   typedef struct packed {
      logic     mode;
      coef_type alpha;
      coef_type beta;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic                  raw;
      logic [SHIFT_BITS-1:0] data;
   } ser_load_type;

endpackage

[hdl/hdve_csr.sv]
// Configuration registers of the hybrid delta varint encoder.
// APB-style write and read port; depends on hdve_pkg.
module hdve_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hdve_pkg::ADDR_BITS-1:0] paddr,
   input  logic [hdve_pkg::DATA_BITS-1:0] pwdata,
   output logic [hdve_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready,
   output hdve_pkg::cfg_type              cfg
);
   import hdve_pkg::*;

   logic     mode_ff, mode_in;
   coef_type alpha_ff, alpha_in;
   coef_type beta_ff, beta_in;
   logic     wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      mode_in  = mode_ff;
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_MODE:  mode_in  = pwdata[0];
            REG_ALPHA: alpha_in = pwdata[COEF_BITS-1:0];
            REG_BETA:  beta_in  = pwdata[COEF_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_MODE:  prdata = DATA_BITS'(mode_ff);
         REG_ALPHA: prdata = DATA_BITS'(alpha_ff);
         REG_BETA:  prdata = DATA_BITS'(beta_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
      end else begin
         mode_ff  <= mode_in;
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   assign cfg.mode  = mode_ff;
   assign cfg.alpha = alpha_ff;
   assign cfg.beta  = beta_ff;

endmodule

[hdl/hdve_mac.sv]
// Bit-serial multiply-accumulate for the hybrid prediction.
// One coefficient bit per cycle, MSB first, then a rounding step; uses hdve_pkg.
module hdve_mac (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  hdve_pkg::value_type    recon,
   input  hdve_pkg::value_type    pfv,
   input  hdve_pkg::coef_type     alpha,
   input  hdve_pkg::coef_type     beta,
   output logic                   done,
   output hdve_pkg::mac_pred_type pred
);
   import hdve_pkg::*;

   localparam int CNT_BITS = $clog2(COEF_BITS + 1);
   localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(COEF_BITS);
   localparam logic signed [ACC_BITS-1:0] ROUND = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   value_type                  xa_ff, xa_in;
   value_type                  xb_ff, xb_in;
   logic [COEF_BITS-1:0]       ca_ff, ca_in;
   logic [COEF_BITS-1:0]       cb_ff, cb_in;
   logic signed [ACC_BITS-1:0] ext_a, ext_b, term_a, term_b;
   logic                       msb_step;

   assign ext_a    = ACC_BITS'(xa_ff);
   assign ext_b    = ACC_BITS'(xb_ff);
   assign msb_step = (cnt_ff == '0);

   always_comb begin
      term_a = '0;
      term_b = '0;
      if (ca_ff[COEF_BITS-1]) begin
         term_a = msb_step ? -ext_a : ext_a;
      end
      if (cb_ff[COEF_BITS-1]) begin
         term_b = msb_step ? -ext_b : ext_b;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      xa_in   = xa_ff;
      xb_in   = xb_ff;
      ca_in   = ca_ff;
      cb_in   = cb_ff;
      priority if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         xa_in   = recon;
         xb_in   = pfv;
         ca_in   = alpha;
         cb_in   = beta;
      end else if (busy_ff && cnt_ff == LAST_CNT) begin
         acc_in  = acc_ff + ROUND;
         busy_in = 1'b0;
         done_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< 1) + term_a + term_b;
         ca_in  = ca_ff << 1;
         cb_in  = cb_ff << 1;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      xa_ff  <= xa_in;
      xb_ff  <= xb_in;
      ca_ff  <= ca_in;
      cb_ff  <= cb_in;
   end

   assign done = done_ff;
   assign pred = acc_ff[ACC_BITS-1:COEF_FRAC_BITS];

endmodule

[hdl/hdve_ser.sv]
// Byte serializer with output register for the encoder; uses hdve_pkg.
// Shifts out raw bytes or 7-bit varint groups, one per cycle while not stalled.
module hdve_ser (
   input  logic                   clock,
   input  logic                   reset,
   input  hdve_pkg::ser_load_type load,
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_byte
);
   import hdve_pkg::*;

   localparam int CNT_BITS = $clog2(RAW_BYTES);
   localparam logic [CNT_BITS-1:0] LAST_RAW = CNT_BITS'(RAW_BYTES - 1);

   logic [SHIFT_BITS-1:0] sr_ff, sr_in;
   logic                  raw_ff, raw_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  active_ff, active_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic                  take, more, cur_last;
   logic [7:0]            cur_byte;

   assign take = !valid_ff || !rsp_stall;
   assign more = |sr_ff[SHIFT_BITS-1:7];

   always_comb begin
      if (raw_ff) begin
         cur_byte = sr_ff[7:0];
         cur_last = (cnt_ff == LAST_RAW);
      end else begin
         cur_byte = (sr_ff[7:0] & GROUP_MASK) | (more ? CONT_BIT : 8'h00);
         cur_last = !more;
      end
   end

   always_comb begin
      sr_in     = sr_ff;
      raw_in    = raw_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      priority if (load.valid && !active_ff) begin
         sr_in     = load.data;
         raw_in    = load.raw;
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff && take) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = cur_last;
         sr_in    = raw_ff ? (sr_ff >> 8) : (sr_ff >> 7);
         cnt_in   = cnt_ff + 1'b1;
         if (cur_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff   <= sr_in;
      raw_ff  <= raw_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign busy          = active_ff;
   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

[hdl/hybrid_delta_varint_encoder.sv]
// Top level of the hybrid delta varint encoder: sequencer, residual and reconstruction.
// Path: ST_LOAD for raw keyframe bytes, ST_DIFF and ST_LOAD for a delta, ST_MUL before
// them for a hybrid later element (16-step bit-serial MAC, rounding step, done handoff).
// Throughput: one byte per cycle unless rsp_stall holds it, 1 to 8 bytes per item; the next
// item's prediction runs while the previous item's bytes drain from the serializer.
// Reset: synchronous; clears the sequencer, the serializer and the reconstruction to zero.
module hybrid_delta_varint_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hdve_pkg::ADDR_BITS-1:0] paddr,
   input  logic [hdve_pkg::DATA_BITS-1:0] pwdata,
   output logic [hdve_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  hdve_pkg::value_type            req_cur_value,
   input  hdve_pkg::value_type            req_prev_frame_value,
   input  logic                           req_first_of_run,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last_byte
);
   import hdve_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIFF = 2'd2;
   localparam logic [1:0] ST_LOAD = 2'd3;

   localparam logic [1:0] PSRC_RECON = 2'd0;
   localparam logic [1:0] PSRC_PFV   = 2'd1;
   localparam logic [1:0] PSRC_MAC   = 2'd2;

   cfg_type                     cfg;
   ser_load_type                ser_load;
   logic                        ser_busy;
   logic                        mac_start, mac_done;
   mac_pred_type                mac_pred;
   logic                        accept;

   logic [1:0]                  state_ff, state_in;
   logic [1:0]                  psrc_ff, psrc_in;
   logic                        raw_ff, raw_in;
   value_type                   cur_ff, cur_in;
   value_type                   pfv_ff, pfv_in;
   value_type                   recon_ff, recon_in;
   logic signed [PRED_BITS-1:0] pred_ff, pred_in;
   logic signed [RES_BITS-1:0]  res_ff, res_in;

   logic signed [PRED_BITS-1:0] pred_sel;
   logic signed [DIFF_BITS-1:0] diff;
   logic signed [SUM_BITS-1:0]  sum;
   logic                        diff_ovf, sum_ovf;
   value_type                   sum_sat;
   logic [RES_BITS-1:0]         zz;

   hdve_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hdve_mac u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .recon (recon_ff),
      .pfv   (req_prev_frame_value),
      .alpha (cfg.alpha),
      .beta  (cfg.beta),
      .done  (mac_done),
      .pred  (mac_pred)
   );

   hdve_ser u_ser (
      .clock         (clock),
      .reset         (reset),
      .load          (ser_load),
      .busy          (ser_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign mac_start = accept && cfg.mode && !req_first_of_run;

   always_comb begin
      unique case (psrc_ff)
         PSRC_RECON: pred_sel = PRED_BITS'(recon_ff);
         PSRC_PFV:   pred_sel = PRED_BITS'(pfv_ff);
         PSRC_MAC:   pred_sel = PRED_BITS'(mac_pred);
         default:    pred_sel = PRED_BITS'(recon_ff);
      endcase
   end

   assign diff     = DIFF_BITS'(cur_ff) - DIFF_BITS'(pred_sel);
   assign diff_ovf = diff[DIFF_BITS-1:RES_BITS-1]
                     != {(DIFF_BITS - RES_BITS + 1){diff[DIFF_BITS-1]}};

   assign sum     = SUM_BITS'(pred_ff) + SUM_BITS'(res_ff);
   assign sum_ovf = sum[SUM_BITS-1:VALUE_BITS-1]
                    != {(SUM_BITS - VALUE_BITS + 1){sum[SUM_BITS-1]}};
   assign sum_sat = sum_ovf ? {sum[SUM_BITS-1], {(VALUE_BITS - 1){~sum[SUM_BITS-1]}}}
                            : sum[VALUE_BITS-1:0];

   assign zz = {res_ff[RES_BITS-2:0], 1'b0} ^ {RES_BITS{res_ff[RES_BITS-1]}};

   always_comb begin
      state_in       = state_ff;
      psrc_in        = psrc_ff;
      raw_in         = raw_ff;
      cur_in         = cur_ff;
      pfv_in         = pfv_ff;
      recon_in       = recon_ff;
      pred_in        = pred_ff;
      res_in         = res_ff;
      ser_load.valid = 1'b0;
      ser_load.raw   = raw_ff;
      ser_load.data  = raw_ff ? SHIFT_BITS'(cur_ff) : SHIFT_BITS'(zz);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in = req_cur_value;
               pfv_in = req_prev_frame_value;
               raw_in = !cfg.mode && req_first_of_run;
               priority if (!cfg.mode) begin
                  psrc_in = PSRC_RECON;
               end else if (req_first_of_run) begin
                  psrc_in = PSRC_PFV;
               end else begin
                  psrc_in = PSRC_MAC;
               end
               priority if (!cfg.mode && req_first_of_run) begin
                  state_in = ST_LOAD;
               end else if (cfg.mode && !req_first_of_run) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_MUL: begin
            if (mac_done) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            pred_in  = pred_sel;
            res_in   = diff_ovf ? {diff[DIFF_BITS-1], {(RES_BITS - 1){~diff[DIFF_BITS-1]}}}
                                : diff[RES_BITS-1:0];
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!ser_busy) begin
               ser_load.valid = 1'b1;
               recon_in       = raw_ff ? cur_ff : sum_sat;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         recon_ff <= '0;
      end else begin
         state_ff <= state_in;
         recon_ff <= recon_in;
      end
   end

   always_ff @(posedge clock) begin
      psrc_ff <= psrc_in;
      raw_ff  <= raw_in;
      cur_ff  <= cur_in;
      pfv_ff  <= pfv_in;
      pred_ff <= pred_in;
      res_ff  <= res_in;
   end

endmodule

[hdl/hdve_chk.sv]
// Port-level checker for the hybrid delta varint encoder, bound to the top level.
// Watches the request and response channels; uses no package.
module hdve_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte))
      else $error("response changed while stalled");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous item still in work");

   a_bytes_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_byte |=> rsp_valid)
      else $error("gap inside one item's byte sequence");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_stall == reset)
      else $error("response valid or input stalled right after reset");

endmodule

bind hybrid_delta_varint_encoder hdve_chk u_hdve_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);
